// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/sbqt_pkg.sv =====
// Package: types and constants of the semaphore queue table
`timescale 1ns / 1ps
package sbqt_pkg;
  localparam int MaxProcs = 32;
  localparam int ProcBits = 5;
  localparam int KeyBits  = 32;

  typedef logic [ProcBits-1:0] proc_t;
  typedef logic [KeyBits-1:0]  key_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_OUT    = 2'd2,
    CMD_HEAD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_INACTIVE = 2'd2,
    ST_NOT_QUED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_DISPATCH,
    S_INS_TAIL,
    S_RD_DESC,
    S_HEAD_DONE,
    S_WALK_RD,
    S_WALK_CHK,
    S_FINISH
  } state_t;
endpackage

// ===== design/sbqt_ram.sv =====
// Generic single-port write, single-port registered read RAM
`timescale 1ns / 1ps
module sbqt_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/semaphore_blocked_queue_table.sv =====
// Flow: a duplicate insert or an out of an unqueued process goes straight to S_FINISH;
// otherwise a key search over the descriptor RAM, then dispatch and the queue update;
// out walks the queue one queued process after another.
// Throughput: one request at a time; busy is high from accept until the strobe cycle.
// Reset (rst_n low, synchronous) clears active and blocked marks and the sequencer; the
// receiver cannot stall, each result shows for one cycle.
`timescale 1ns / 1ps
module semaphore_blocked_queue_table import sbqt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_command,
  input  logic [31:0]   in_sem_address,
  input  logic [4:0]    in_proc_id,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic          out_proc_valid,
  output logic [4:0]    out_result_proc
);
  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  key_t   key_r, key_nxt;
  proc_t  p_r, p_nxt;
  proc_t  idx_r, idx_nxt;
  logic   found_r, found_nxt, free_r, free_nxt;
  proc_t  fd_r, fd_nxt, ff_r, ff_nxt;
  logic   srch_rd_r, srch_rd_nxt;
  proc_t  srch_d_r, srch_d_nxt;
  proc_t  cur_r, cur_nxt, prev_r, prev_nxt;
  logic   first_r, first_nxt;
  proc_t  tail_r, tail_nxt;
  logic   [MaxProcs-1:0] act_r, act_nxt, blk_r, blk_nxt;
  logic   [1:0] st_r, st_nxt;
  logic   pv_r, pv_nxt;
  proc_t  rp_r, rp_nxt;
  logic   ov_r, ov_nxt;

  // RAM ports
  logic  kw_we;  proc_t kw_a, kr_a;  key_t kw_d, kr_q;
  logic  hw_we;  proc_t hw_a, hr_a;  proc_t hw_d, hr_q;
  logic  tw_we;  proc_t tw_a, tr_a;  proc_t tw_d, tr_q;
  logic  nw_we;  proc_t nw_a, nr_a;  proc_t nw_d, nr_q;
  logic  pw_we;  proc_t pw_a, pr_a;  key_t pw_d, pr_q;

  sbqt_ram #(.Width(KeyBits), .Depth(MaxProcs)) u_key (.clk, .we(kw_we), .waddr(kw_a),
    .wdata(kw_d), .raddr(kr_a), .rdata(kr_q));
  sbqt_ram #(.Width(ProcBits), .Depth(MaxProcs)) u_head (.clk, .we(hw_we), .waddr(hw_a),
    .wdata(hw_d), .raddr(hr_a), .rdata(hr_q));
  sbqt_ram #(.Width(ProcBits), .Depth(MaxProcs)) u_tail (.clk, .we(tw_we), .waddr(tw_a),
    .wdata(tw_d), .raddr(tr_a), .rdata(tr_q));
  sbqt_ram #(.Width(ProcBits), .Depth(MaxProcs)) u_next (.clk, .we(nw_we), .waddr(nw_a),
    .wdata(nw_d), .raddr(nr_a), .rdata(nr_q));
  sbqt_ram #(.Width(KeyBits), .Depth(MaxProcs)) u_pkey (.clk, .we(pw_we), .waddr(pw_a),
    .wdata(pw_d), .raddr(pr_a), .rdata(pr_q));

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_proc_valid  = pv_r;
  assign out_result_proc = rp_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= '0;
      blk_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      act_r   <= act_nxt;
      blk_r   <= blk_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  key_r <= key_nxt;  p_r <= p_nxt;  idx_r <= idx_nxt;
    found_r <= found_nxt;  free_r <= free_nxt;  fd_r <= fd_nxt;  ff_r <= ff_nxt;
    srch_rd_r <= srch_rd_nxt;  srch_d_r <= srch_d_nxt;
    cur_r <= cur_nxt;  prev_r <= prev_nxt;  first_r <= first_nxt;
    tail_r <= tail_nxt;
    st_r <= st_nxt;  pv_r <= pv_nxt;  rp_r <= rp_nxt;
  end

  // sequencer: next state, RAM control and result
  always_comb begin
    state_nxt = state_r;  cmd_nxt = cmd_r;  key_nxt = key_r;  p_nxt = p_r;
    idx_nxt = idx_r;  found_nxt = found_r;  free_nxt = free_r;
    fd_nxt = fd_r;  ff_nxt = ff_r;  srch_rd_nxt = 1'b0;  srch_d_nxt = srch_d_r;
    cur_nxt = cur_r;  prev_nxt = prev_r;  first_nxt = first_r;
    tail_nxt = tail_r;
    act_nxt = act_r;  blk_nxt = blk_r;
    st_nxt = st_r;  pv_nxt = pv_r;  rp_nxt = rp_r;  ov_nxt = 1'b0;
    kw_we = 1'b0;  kw_a = '0;  kw_d = key_r;  kr_a = idx_r;
    hw_we = 1'b0;  hw_a = fd_r;  hw_d = p_r;  hr_a = fd_r;
    tw_we = 1'b0;  tw_a = fd_r;  tw_d = p_r;  tr_a = fd_r;
    nw_we = 1'b0;  nw_a = tail_r;  nw_d = p_r;  nr_a = cur_r;
    pw_we = 1'b0;  pw_a = p_r;  pw_d = key_r;  pr_a = in_proc_id;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_command);
          key_nxt = in_sem_address;
          p_nxt   = in_proc_id;
          st_nxt  = ST_OK;  pv_nxt = 1'b0;  rp_nxt = '0;
          idx_nxt = '0;  found_nxt = 1'b0;  free_nxt = 1'b0;
          if (cmd_t'(in_command) == CMD_INSERT && blk_r[in_proc_id]) begin
            state_nxt = S_FINISH;
          end else if (cmd_t'(in_command) == CMD_OUT && !blk_r[in_proc_id]) begin
            st_nxt = ST_NOT_QUED;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      // walk the descriptors, one key read a cycle, compare the one before
      S_SEARCH: begin
        srch_rd_nxt = 1'b1;
        srch_d_nxt  = idx_r;
        idx_nxt     = idx_r + 1'b1;
        if (srch_rd_r) begin
          if (!found_r && act_r[srch_d_r] && kr_q == key_r) begin
            found_nxt = 1'b1;  fd_nxt = srch_d_r;
          end
          if (!free_r && !act_r[srch_d_r]) begin
            free_nxt = 1'b1;  ff_nxt = srch_d_r;
          end
          if (srch_d_r == proc_t'(MaxProcs-1)) begin
            srch_rd_nxt = 1'b0;
            state_nxt = S_DISPATCH;
          end
        end
      end
      S_DISPATCH: begin
        if (!found_r) begin
          if (cmd_r == CMD_INSERT) begin
            if (!free_r) begin
              st_nxt = ST_NO_FREE;
            end else begin
              act_nxt[ff_r] = 1'b1;
              kw_we = 1'b1;  kw_a = ff_r;
              hw_we = 1'b1;  hw_a = ff_r;
              tw_we = 1'b1;  tw_a = ff_r;
              pw_we = 1'b1;  blk_nxt[p_r] = 1'b1;
            end
          end else begin
            st_nxt = ST_INACTIVE;
          end
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_RD_DESC;
        end
      end
      S_RD_DESC: begin
        // head and tail RAM outputs for fd now valid next cycle
        state_nxt = S_HEAD_DONE;
      end
      S_HEAD_DONE: begin
        tail_nxt = tr_q;
        if (cmd_r == CMD_INSERT) begin
          tail_nxt = tr_q;
          state_nxt = S_INS_TAIL;
        end else if (cmd_r == CMD_OUT) begin
          cur_nxt = hr_q;  first_nxt = 1'b1;
          state_nxt = S_WALK_RD;
        end else begin
          pv_nxt = 1'b1;  rp_nxt = hr_q;
          if (cmd_r == CMD_REMOVE) begin
            blk_nxt[hr_q] = 1'b0;
            if (tr_q == hr_q) begin
              act_nxt[fd_r] = 1'b0;
              state_nxt = S_FINISH;
            end else begin
              cur_nxt = hr_q;
              state_nxt = S_WALK_RD;
            end
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_INS_TAIL: begin
        nw_we = 1'b1;  nw_a = tail_r;
        tw_we = 1'b1;  tw_a = fd_r;
        pw_we = 1'b1;  blk_nxt[p_r] = 1'b1;
        state_nxt = S_FINISH;
      end
      // read next pointer of cur
      S_WALK_RD: begin
        nr_a = cur_r;
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (cmd_r == CMD_REMOVE) begin
          hw_we = 1'b1;  hw_a = fd_r;  hw_d = nr_q;
          state_nxt = S_FINISH;
        end else if (cur_r == p_r) begin
          if (first_r && tail_r == cur_r) begin
            act_nxt[fd_r] = 1'b0;
          end else if (first_r) begin
            hw_we = 1'b1;  hw_d = nr_q;
          end else begin
            nw_we = 1'b1;  nw_a = prev_r;  nw_d = nr_q;
            if (tail_r == cur_r) begin
              tw_we = 1'b1;  tw_d = prev_r;
            end
          end
          blk_nxt[p_r] = 1'b0;
          pv_nxt = 1'b1;  rp_nxt = p_r;
          state_nxt = S_FINISH;
        end else if (tail_r == cur_r) begin
          st_nxt = ST_NOT_QUED;
          state_nxt = S_FINISH;
        end else begin
          prev_nxt = cur_r;  first_nxt = 1'b0;  cur_nxt = nr_q;
          state_nxt = S_WALK_RD;
        end
      end
      S_FINISH: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // out: take key from the process key RAM read issued at accept
    if (state_r == S_SEARCH && cmd_r == CMD_OUT && !srch_rd_r && idx_r == '0) begin
      key_nxt = pr_q;
    end
  end
endmodule

// ===== design/sbqt_checker.sv =====
// Port-level checker for the semaphore queue table, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sbqt_checker import sbqt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_proc_valid,
  input logic [4:0] out_result_proc
);
  `ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_NXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMP(a_pv_ok, clk, rst_n, out_valid && out_proc_valid, out_status == ST_OK)
  `ASSERT_IMP(a_zero_proc, clk, rst_n, out_valid && !out_proc_valid, out_result_proc == 5'd0)
endmodule

bind semaphore_blocked_queue_table sbqt_checker u_chk (.clk, .rst_n, .start, .busy,
  .out_valid, .out_status, .out_proc_valid, .out_result_proc);

// ===== verif/testbench.sv =====
// Testbench for the semaphore blocked-queue table: scoreboard against a behavioral queue model
`timescale 1ns / 1ps
module testbench;
  import sbqt_pkg::*;

  typedef struct packed {
    cmd_t  cmd;
    key_t  key;
    proc_t pid;
  } request_t;

  typedef struct packed {
    status_t status;
    logic    pvalid;
    proc_t   rproc;
  } answer_t;

  localparam int LimitCycles = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [31:0] in_sem_address;
  logic [4:0]  in_proc_id;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_proc_valid;
  logic [4:0]  out_result_proc;

  semaphore_blocked_queue_table u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_sem_address(in_sem_address), .in_proc_id(in_proc_id),
    .out_valid(out_valid), .out_status(out_status), .out_proc_valid(out_proc_valid),
    .out_result_proc(out_result_proc)
  );

  // Table model state
  key_t  m_key      [MaxProcs];
  logic  m_active   [MaxProcs];
  proc_t m_head     [MaxProcs];
  proc_t m_tail     [MaxProcs];
  proc_t m_next     [MaxProcs];
  key_t  m_proc_key [MaxProcs];
  logic  m_blocked  [MaxProcs];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  key_t     key_pool[8];
  int       errors = 0;
  int       cycles = 0;
  bit       hold_sender;
  bit       quiet_stretch;
  bit       in_flight;

  function automatic int find_desc(key_t k);
    for (int d = 0; d < MaxProcs; d++)
      if (m_active[d] && m_key[d] == k) return d;
    return -1;
  endfunction

  function automatic int find_free_desc();
    for (int d = 0; d < MaxProcs; d++)
      if (!m_active[d]) return d;
    return -1;
  endfunction

  // Apply one request to the model and return its answer
  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    int d;
    proc_t cur, prev;
    bit first, done;
    a = '{ST_OK, 1'b0, '0};
    case (r.cmd)
      CMD_INSERT: begin
        if (!m_blocked[r.pid]) begin
          d = find_desc(r.key);
          if (d >= 0) begin
            m_next[m_tail[d]] = r.pid;
            m_tail[d] = r.pid;
          end else begin
            d = find_free_desc();
            if (d < 0) a.status = ST_NO_FREE;
            else begin
              m_active[d] = 1'b1;
              m_key[d] = r.key;
              m_head[d] = r.pid;
              m_tail[d] = r.pid;
            end
          end
          if (a.status == ST_OK) begin
            m_proc_key[r.pid] = r.key;
            m_blocked[r.pid] = 1'b1;
          end
        end
      end
      CMD_OUT: begin
        if (!m_blocked[r.pid]) a.status = ST_NOT_QUED;
        else begin
          d = find_desc(m_proc_key[r.pid]);
          if (d < 0) a.status = ST_INACTIVE;
          else begin
            // Walk the queue and unlink the named process
            cur = m_head[d];
            prev = '0;
            first = 1'b1;
            done = 1'b0;
            for (int s = 0; s < MaxProcs && !done; s++) begin
              if (cur == r.pid) begin
                if (first && m_tail[d] == cur) m_active[d] = 1'b0;
                else if (first) m_head[d] = m_next[cur];
                else begin
                  m_next[prev] = m_next[cur];
                  if (m_tail[d] == cur) m_tail[d] = prev;
                end
                m_blocked[r.pid] = 1'b0;
                a.pvalid = 1'b1;
                a.rproc = r.pid;
                done = 1'b1;
              end else if (m_tail[d] == cur) begin
                a.status = ST_NOT_QUED;
                done = 1'b1;
              end else begin
                prev = cur;
                first = 1'b0;
                cur = m_next[cur];
              end
            end
            if (!done) a.status = ST_NOT_QUED;
          end
        end
      end
      default: begin
        d = find_desc(r.key);
        if (d < 0) a.status = ST_INACTIVE;
        else begin
          a.pvalid = 1'b1;
          a.rproc = m_head[d];
          if (r.cmd == CMD_REMOVE) begin
            if (m_tail[d] == m_head[d]) m_active[d] = 1'b0;
            else m_head[d] = m_next[m_head[d]];
            m_blocked[a.rproc] = 1'b0;
          end
        end
      end
    endcase
    return a;
  endfunction

  function automatic request_t make_req(cmd_t c, key_t k, proc_t p);
    request_t r;
    r.cmd = c;
    r.key = k;
    r.pid = p;
    return r;
  endfunction

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive requests; accept when start is high and busy is low
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_flight <= 1'b0;
      in_command <= CMD_INSERT;
      in_sem_address <= '0;
      in_proc_id <= '0;
    end else begin
      if (start && !busy) begin
        expected_answers.push_back(predict_answer(
          make_req(cmd_t'(in_command), in_sem_address, in_proc_id)));
        in_flight <= 1'b1;
      end else if (out_valid) begin
        in_flight <= 1'b0;
      end
      if (start && !busy) begin
        if (pending_reqs.size() > 0 && !hold_sender &&
            (quiet_stretch || $urandom_range(99) >= 18)) begin
          in_command     <= pending_reqs[0].cmd;
          in_sem_address <= pending_reqs[0].key;
          in_proc_id     <= pending_reqs[0].pid;
          void'(pending_reqs.pop_front());
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_reqs.size() > 0 && !hold_sender &&
                   (quiet_stretch || $urandom_range(99) >= 18)) begin
        start          <= 1'b1;
        in_command     <= pending_reqs[0].cmd;
        in_sem_address <= pending_reqs[0].key;
        in_proc_id     <= pending_reqs[0].pid;
        void'(pending_reqs.pop_front());
      end
    end
  end

  // Check each result strobe against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result status=%0d proc_valid=%0d proc=%0d", $time,
                 out_status, out_proc_valid, out_result_proc);
        errors++;
      end else begin
        want = expected_answers.pop_front();
        if (out_status !== want.status || out_proc_valid !== want.pvalid ||
            out_result_proc !== want.rproc) begin
          $display({"%0t: mismatch expected status=%0d proc_valid=%0d proc=%0d,",
                    " actual status=%0d proc_valid=%0d proc=%0d"},
                   $time, want.status, want.pvalid, want.rproc,
                   out_status, out_proc_valid, out_result_proc);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("semaphore_blocked_queue_table regression: fail");
      $finish;
    end
  end

  function automatic request_t random_req();
    int sel;
    cmd_t c;
    key_t k;
    sel = $urandom_range(99);
    c = cmd_t'($urandom_range(3));
    if (sel < 45) c = CMD_INSERT;
    // Mostly reuse a small key pool so queues grow and commands hit
    k = ($urandom_range(9) == 0) ? key_t'($urandom) : key_pool[$urandom_range(7)];
    return make_req(c, k, proc_t'($urandom_range(MaxProcs - 1)));
  endfunction

  initial begin
    hold_sender = 1'b0;
    quiet_stretch = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i < MaxProcs; i++) begin
      m_active[i] = 1'b0;
      m_blocked[i] = 1'b0;
      m_key[i] = '0;
      m_head[i] = '0;
      m_tail[i] = '0;
      m_next[i] = '0;
      m_proc_key[i] = '0;
    end
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFE,
                 32'hAAAA_5555, 32'h5555_AAAA, 32'h1234_5678, 32'h8000_0000};

    // Directed: empty-table misses, key extremes, duplicate insert, out of middle and tail
    pending_reqs.push_back(make_req(CMD_HEAD,   32'h0, 5'd0));
    pending_reqs.push_back(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 5'd0));
    pending_reqs.push_back(make_req(CMD_OUT,    32'h0, 5'd31));
    pending_reqs.push_back(make_req(CMD_INSERT, 32'h0, 5'd0));
    pending_reqs.push_back(make_req(CMD_INSERT, 32'hFFFF_FFFF, 5'd31));
    pending_reqs.push_back(make_req(CMD_INSERT, 32'h0, 5'd1));
    pending_reqs.push_back(make_req(CMD_INSERT, 32'h0, 5'd2));
    pending_reqs.push_back(make_req(CMD_INSERT, 32'h0, 5'd1));
    pending_reqs.push_back(make_req(CMD_HEAD,   32'h0, 5'd0));
    pending_reqs.push_back(make_req(CMD_OUT,    32'h0, 5'd1));
    pending_reqs.push_back(make_req(CMD_OUT,    32'h0, 5'd2));
    pending_reqs.push_back(make_req(CMD_REMOVE, 32'h0, 5'd0));
    pending_reqs.push_back(make_req(CMD_HEAD,   32'h0, 5'd0));
    pending_reqs.push_back(make_req(CMD_HEAD,   32'hFFFF_FFFF, 5'd0));
    pending_reqs.push_back(make_req(CMD_OUT,    32'h0, 5'd31));
    pending_reqs.push_back(make_req(CMD_OUT,    32'h0, 5'd31));
    // Fill every descriptor with its own key, then insert an already blocked process
    for (int i = 0; i < MaxProcs; i++)
      pending_reqs.push_back(make_req(CMD_INSERT, 32'h100 + i, proc_t'(i)));
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    pending_reqs.push_back(make_req(CMD_INSERT, 32'hDEAD_0000, 5'd5));
    for (int i = 0; i < MaxProcs; i++)
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'h100 + i, 5'd0));

    // Pause the sender until everything drains
    wait (pending_reqs.size() == 0);
    hold_sender = 1'b1;
    wait (!start && !in_flight && expected_answers.size() == 0);
    @(posedge clk);
    hold_sender = 1'b0;

    // Random part with a stretch of no idling
    for (int i = 0; i < 600; i++) begin
      if (i == 200) begin
        wait (pending_reqs.size() == 0);
        quiet_stretch = 1'b1;
      end
      if (i == 320) begin
        wait (pending_reqs.size() == 0);
        quiet_stretch = 1'b0;
      end
      pending_reqs.push_back(random_req());
    end

    wait (pending_reqs.size() == 0 && !start);
    wait (!in_flight && expected_answers.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0)
      $display("semaphore_blocked_queue_table regression: pass");
    else
      $display("semaphore_blocked_queue_table regression: fail");
    $finish;
  end
endmodule
